### design/bse_pkg.sv
// shared constants for the bubble sort block
`default_nettype none

package bse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DW        = 32;
    localparam int AW        = $clog2(MAX_ITEMS);
    localparam int CW        = $clog2(MAX_ITEMS + 1);

endpackage

`default_nettype wire

### design/bse_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/bse_cmp.sv
// compare-and-route unit: keeps the larger value, passes the smaller one down
`default_nettype none

module bse_cmp (
    input  wire logic signed [bse_pkg::DW-1:0] i_carry,
    input  wire logic signed [bse_pkg::DW-1:0] i_next,
    output logic                               o_swap,
    output logic signed      [bse_pkg::DW-1:0] o_low,
    output logic signed      [bse_pkg::DW-1:0] o_high
);

    // carried value greater than the next entry means a swap in this step
    assign o_swap = i_carry > i_next;
    assign o_low  = o_swap ? i_next  : i_carry;
    assign o_high = o_swap ? i_carry : i_next;

endmodule

`default_nettype wire

### design/bubble_sort_early_exit.sv
// top level of the bubble sort block with early exit
//
// usage
//   - present i_value and i_last with start high; a transaction is taken at a
//     rising edge where start is high and busy is low
//   - values are stored in arrival order; values beyond 64 are dropped and
//     the set is flagged as overflowed
//   - a transaction with i_last high ends the set: busy rises and the block
//     sorts the stored values ascending (signed), then streams them out
//   - each result shows on o_value_res / o_last_res / o_overflowed for one
//     cycle with o_valid high; the receiver cannot stall the stream
//   - o_last_res marks the final sorted value; busy drops in the cycle after it
// timing
//   - loading: one value per cycle while busy is low, no wait between values
//   - each bubble pass over len entries runs through one compare unit fed
//     by the single read port of the store ram
//   - up to n - 1 passes, fewer when a pass makes no swap
// reset
//   - i_rst_n low clears the set count, the overflow flag and the sequencer;
//     store contents are not cleared and need no clearing pass
`default_nettype none

module bubble_sort_early_exit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [bse_pkg::DW-1:0]      i_value,
    input  wire logic                               i_last,
    output logic                                    o_valid,
    output logic signed      [bse_pkg::DW-1:0]      o_value_res,
    output logic                                    o_last_res,
    output logic                                    o_overflowed
);

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,  // idle, taking values
        S_FIRST = 6'b000010,  // read entry 0 for the first pass
        S_LOADC = 6'b000100,  // entry 0 arrives into the carry register
        S_PASS  = 6'b001000,  // compare carry with next entry, write smaller down
        S_TAIL  = 6'b010000,  // write the carried maximum at the end of the pass
        S_EMIT  = 6'b100000   // stream sorted entries out
    } t_state;

    t_state r_state, n_state;

    logic [bse_pkg::CW-1:0] r_count, n_count;  // values held in this set
    logic                   r_dropped, n_dropped;
    logic [bse_pkg::CW-1:0] r_len, n_len;      // length of the current pass
    logic [bse_pkg::CW-1:0] r_idx, n_idx;      // next read address
    logic signed [bse_pkg::DW-1:0] r_carry, n_carry;
    logic                   r_swp, n_swp;      // any swap in the current pass
    logic                   r_ovld, n_ovld;
    logic                   r_olast, n_olast;
    logic                   r_done, n_done;    // final result is on the ports

    // ram ports
    logic                          w_we;
    logic [bse_pkg::AW-1:0]        w_waddr;
    logic [bse_pkg::DW-1:0]        w_wdata;
    logic [bse_pkg::AW-1:0]        w_raddr;
    logic [bse_pkg::DW-1:0]        w_rdata;

    // compare unit
    logic                          w_swap;
    logic signed [bse_pkg::DW-1:0] w_low;
    logic signed [bse_pkg::DW-1:0] w_high;

    logic                          w_take;
    logic                          w_room;
    logic [bse_pkg::CW-1:0]        w_wr_k;     // write-back address in a pass
    logic [bse_pkg::CW-1:0]        w_tail_k;
    logic [bse_pkg::CW-1:0]        w_cnt_m1;

    assign busy     = (r_state != S_LOAD) || r_done;
    assign w_take   = start && !busy;
    assign w_room   = r_count < bse_pkg::CW'(bse_pkg::MAX_ITEMS);
    assign w_wr_k   = r_idx - bse_pkg::CW'(2);
    assign w_tail_k = r_len - bse_pkg::CW'(1);
    assign w_cnt_m1 = r_count - bse_pkg::CW'(1);

    bse_ram #(
        .WIDTH (bse_pkg::DW),
        .DEPTH (bse_pkg::MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bse_cmp u_cmp (
        .i_carry (r_carry),
        .i_next  (w_rdata),
        .o_swap  (w_swap),
        .o_low   (w_low),
        .o_high  (w_high)
    );

    // read address: entry 0 at the start of a pass, otherwise the walking index
    assign w_raddr = (r_state == S_FIRST || r_state == S_TAIL) ?
                     '0 : r_idx[bse_pkg::AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_len     = r_len;
        n_idx     = r_idx;
        n_carry   = r_carry;
        n_swp     = r_swp;
        n_ovld    = 1'b0;
        n_olast   = 1'b0;
        n_done    = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_count[bse_pkg::AW-1:0];
        w_wdata   = i_value;

        unique case (r_state)
            S_LOAD: begin
                if (r_done) begin
                    // final result leaves now, set bookkeeping restarts
                    n_count   = '0;
                    n_dropped = 1'b0;
                end else if (w_take) begin
                    if (w_room) begin
                        w_we    = 1'b1;
                        n_count = r_count + bse_pkg::CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_last) begin
                        n_len = n_count;
                        n_idx = '0;
                        if (n_count >= bse_pkg::CW'(2)) begin
                            n_state = S_FIRST;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_FIRST: begin
                n_idx   = bse_pkg::CW'(1);
                n_state = S_LOADC;
            end
            S_LOADC: begin
                n_carry = w_rdata;
                n_swp   = 1'b0;
                n_idx   = r_idx + bse_pkg::CW'(1);
                n_state = S_PASS;
            end
            S_PASS: begin
                w_we    = 1'b1;
                w_waddr = w_wr_k[bse_pkg::AW-1:0];
                w_wdata = w_low;
                n_carry = w_high;
                n_swp   = r_swp || w_swap;
                if (r_idx == r_len) begin
                    n_state = S_TAIL;
                end else begin
                    n_idx = r_idx + bse_pkg::CW'(1);
                end
            end
            S_TAIL: begin
                w_we    = 1'b1;
                w_waddr = w_tail_k[bse_pkg::AW-1:0];
                w_wdata = r_carry;
                // early exit when a pass made no swap or nothing is left to sort
                if (r_swp && w_tail_k >= bse_pkg::CW'(2)) begin
                    n_len   = w_tail_k;
                    n_idx   = bse_pkg::CW'(1);
                    n_state = S_LOADC;
                end else begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_ovld  = 1'b1;
                n_olast = (r_idx == w_cnt_m1);
                n_idx   = r_idx + bse_pkg::CW'(1);
                if (r_idx == w_cnt_m1) begin
                    n_done  = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_ovld    <= 1'b0;
            r_olast   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_ovld    <= n_ovld;
            r_olast   <= n_olast;
            r_done    <= n_done;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_idx   <= n_idx;
        r_carry <= n_carry;
        r_swp   <= n_swp;
    end

    // ram read data is already registered and lines up with the strobe
    assign o_valid      = r_ovld;
    assign o_value_res  = w_rdata;
    assign o_last_res   = r_olast;
    assign o_overflowed = r_dropped;

    // results only stream while emitting or in the cycle of the final result
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_state == S_EMIT || r_done))
        else $error("result strobe outside emit");

    // the final result ends the set and the block is free in the cycle after it
    a_free_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_res) |=> !busy)
        else $error("block still busy after final result");

    // a pass never runs with fewer than two entries
    a_pass_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS || r_state == S_LOADC) |-> r_len >= bse_pkg::CW'(2))
        else $error("bubble pass shorter than two entries");

    // the set count never passes the store size
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bse_pkg::CW'(bse_pkg::MAX_ITEMS))
        else $error("set count beyond store size");

endmodule

`default_nettype wire

### verif/tb.sv
// self-checking testbench for the bubble sort block with early exit
`default_nettype none

module tb;

    // one sorted value as the block should emit it
    typedef struct packed {
        logic signed [bse_pkg::DW-1:0] value;
        logic                          last;
        logic                          overflowed;
    } t_sorted_word;

    localparam int TOTAL_VALUES = 410;
    localparam int IDLE_PERCENT = 37;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start   = 1'b0;
    logic signed [bse_pkg::DW-1:0] i_value = '0;
    logic                          i_last  = 1'b0;
    logic                          busy;
    logic                          o_valid;
    logic signed [bse_pkg::DW-1:0] o_value_res;
    logic                          o_last_res;
    logic                          o_overflowed;

    // own copy of the set being collected: values held in arrival order and
    // whether anything was dropped for lack of room
    logic signed [bse_pkg::DW-1:0] held_values[$];
    logic                          held_dropped = 1'b0;

    // sorted values still owed by the block, oldest first
    t_sorted_word                  expected_sorted[$];

    int                            error_count = 0;
    int                            sent_count  = 0;
    bit                            idle_on     = 1'b1;

    bubble_sort_early_exit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .o_value_res  (o_value_res),
        .o_last_res   (o_last_res),
        .o_overflowed (o_overflowed)
    );

    always #1 i_clk = ~i_clk;

    // absolute guard against a hung handshake or a lost result
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // predictor: take one accepted transaction into the held set; on the
    // last flag sort the held values ascending (signed) and queue them as
    // the expected result stream, then start a fresh set
    task automatic collect_and_sort(input logic signed [bse_pkg::DW-1:0] v,
                                    input logic l);
        logic signed [bse_pkg::DW-1:0] work [bse_pkg::MAX_ITEMS];
        logic signed [bse_pkg::DW-1:0] t;
        t_sorted_word                  w;
        int                            n;
        int                            j;
        // a full store drops the value but still honors its last flag
        if (held_values.size() < bse_pkg::MAX_ITEMS)
            held_values.push_back(v);
        else
            held_dropped = 1'b1;
        if (l) begin
            n = held_values.size();
            for (int k = 0; k < n; k++)
                work[k] = held_values[k];
            // plain insertion sort; any correct sort yields the same order
            for (int k = 1; k < n; k++) begin
                t = work[k];
                j = k - 1;
                while (j >= 0 && work[j] > t) begin
                    work[j + 1] = work[j];
                    j--;
                end
                work[j + 1] = t;
            end
            for (int k = 0; k < n; k++) begin
                w.value      = work[k];
                w.last       = (k == n - 1);
                w.overflowed = held_dropped;
                expected_sorted.push_back(w);
            end
            // end of set: count and overflow flag go back to zero
            held_values.delete();
            held_dropped = 1'b0;
        end
    endtask

    // drive one transaction, optionally after random idle cycles, and hold it
    // until the block takes it (start high and busy low at a rising edge)
    task automatic send_value(input logic signed [bse_pkg::DW-1:0] v, input logic l);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            // idle cycle with junk on the payload, the block must ignore it
            start   <= 1'b0;
            i_value <= $urandom();
            i_last  <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        i_last  <= l;
        // busy read here is its value before this edge
        do @(posedge i_clk); while (busy);
        sent_count++;
        collect_and_sort(v, l);
    endtask

    // mix of full-range words, small clustered values and the extremes,
    // so that duplicates and sign boundaries show up often
    function automatic logic signed [bse_pkg::DW-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom();
        else if (r < 75)
            return $signed($urandom_range(0, 15)) - 8;
        else if (r < 90) begin
            unique case ($urandom_range(0, 3))
                0:       return {1'b0, {(bse_pkg::DW-1){1'b1}}};
                1:       return {1'b1, {(bse_pkg::DW-1){1'b0}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        else
            return $signed($urandom_range(0, 3)) * 32'sd1000;
    endfunction

    // one set of n stored values followed by extra values that overflow;
    // the last flag always rides on the final transaction of the set
    task automatic send_random_set(input int n, input int extra);
        for (int k = 0; k < n + extra; k++)
            send_value(pick_value(), k == n + extra - 1);
    endtask

    // set of one value, the shortest sort
    task automatic test_single_value();
        send_value(32'sd42, 1'b1);
    endtask

    // sign boundaries: most positive, most negative, zero, minus one, one
    task automatic test_signed_extremes();
        send_value({1'b0, {(bse_pkg::DW-1){1'b1}}}, 1'b0);
        send_value({1'b1, {(bse_pkg::DW-1){1'b0}}}, 1'b0);
        send_value('0, 1'b0);
        send_value('1, 1'b0);
        send_value(32'sd1, 1'b0);
        send_value({1'b1, {(bse_pkg::DW-1){1'b0}}}, 1'b1);
    endtask

    // already ascending: the first pass makes no swap, early exit
    task automatic test_presorted_set();
        send_value(-32'sd20, 1'b0);
        send_value(-32'sd3, 1'b0);
        send_value(32'sd0, 1'b0);
        send_value(32'sd7, 1'b0);
        send_value(32'sd1000, 1'b1);
    endtask

    // strictly descending: every pass swaps, full pass count
    task automatic test_reversed_set();
        for (int k = 0; k < 6; k++)
            send_value(32'sd500 - k * 32'sd150, k == 5);
    endtask

    // equal neighbors must not swap and must all come out
    task automatic test_repeated_values();
        send_value(32'sd5, 1'b0);
        send_value(-32'sd5, 1'b0);
        send_value(32'sd5, 1'b0);
        send_value(32'sd5, 1'b0);
        send_value(-32'sd5, 1'b1);
    endtask

    // exactly a full store, last flag on the final stored value
    task automatic test_full_store();
        send_random_set(bse_pkg::MAX_ITEMS, 0);
    endtask

    // store full, extra values dropped, last flag on a dropped value;
    // the following short set checks that the overflow flag was cleared
    task automatic test_overflow_set();
        send_random_set(bse_pkg::MAX_ITEMS, 3);
        send_random_set(3, 0);
    endtask

    // random sets, mostly small with a few large and overflowing ones;
    // a stretch in the middle runs with no gaps at all
    task automatic test_random_sets();
        int r;
        int n;
        int mark;
        mark = sent_count;
        while (sent_count < TOTAL_VALUES) begin
            idle_on = !((sent_count - mark) > 100 && (sent_count - mark) < 220);
            r = $urandom_range(0, 99);
            if (r < 70)
                n = $urandom_range(1, 12);
            else if (r < 90)
                n = $urandom_range(13, 40);
            else if (r < 97)
                n = $urandom_range(41, bse_pkg::MAX_ITEMS);
            else
                n = bse_pkg::MAX_ITEMS;
            send_random_set(n, (r >= 97) ? $urandom_range(1, 3) : 0);
        end
        idle_on = 1'b1;
    endtask

    // result checker: every strobe is compared with the oldest expectation
    always @(posedge i_clk) begin
        t_sorted_word e;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_sorted.size() == 0) begin
                $display("%0t: unexpected result value=%0d last=%b ovf=%b",
                         $time, o_value_res, o_last_res, o_overflowed);
                error_count++;
            end else begin
                e = expected_sorted.pop_front();
                if (o_value_res !== e.value) begin
                    $display("%0t: value mismatch exp=%0d act=%0d",
                             $time, e.value, o_value_res);
                    error_count++;
                end
                if (o_last_res !== e.last) begin
                    $display("%0t: last mismatch exp=%b act=%b",
                             $time, e.last, o_last_res);
                    error_count++;
                end
                if (o_overflowed !== e.overflowed) begin
                    $display("%0t: overflow flag mismatch exp=%b act=%b",
                             $time, e.overflowed, o_overflowed);
                    error_count++;
                end
            end
        end
    end

    initial begin
        // synchronous reset asserted once at the start
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_value();
        test_signed_extremes();
        test_presorted_set();
        test_reversed_set();
        test_repeated_values();
        test_full_store();
        test_overflow_set();
        test_random_sets();

        // no more transactions; let the last set drain, then settle
        start <= 1'b0;
        while (expected_sorted.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
design/bse_pkg.sv
design/bse_ram.sv
design/bse_cmp.sv
design/bubble_sort_early_exit.sv
verif/tb.sv
